### rtl/ccl21_pkg.sv
// Shared constants and types for the line 21 caption data slicer.
// Used by the cell, divider and top level modules; depends on nothing.
`timescale 1ns / 1ps
package ccl21_pkg;

  localparam int LINE_DEPTH   = 2048;
  localparam int ADDR_W       = $clog2(LINE_DEPTH);
  localparam int SEARCH_FIRST = 35;
  localparam int SEARCH_END   = 50;
  localparam int N_CELLS      = SEARCH_END - SEARCH_FIRST;
  localparam int CELL_W       = $clog2(N_CELLS);
  localparam int START_OFFSET = 512;
  localparam int BIT_SPACING  = 57;
  localparam int BIT_WINDOW   = 23;
  localparam int WIN_W        = $clog2(BIT_WINDOW + 1);

  localparam int PH_W   = 16;
  localparam int WL_W   = 10;
  localparam int CNT_W  = WL_W;
  localparam int SUM_W  = CNT_W + 8;
  localparam int BSUM_W = $clog2(BIT_WINDOW * 255 + 1);

  localparam logic [PH_W-1:0] PHASE_LOW_EDGE  = 16'h4000;
  localparam logic [PH_W-1:0] PHASE_HIGH_EDGE = 16'hC000;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_CLOCK_RECIP = 3'd0;
  localparam logic [2:0] REG_WINDOW_LEN  = 3'd1;
  localparam logic [2:0] REG_MIN_AMP     = 3'd2;
  localparam logic [2:0] REG_START_THR   = 3'd3;
  localparam logic [2:0] REG_BIT_THR     = 3'd4;

  localparam logic [15:0] RST_CLOCK_RECIP = 16'd1152;
  localparam logic [9:0]  RST_WINDOW_LEN  = 10'd369;
  localparam logic [7:0]  RST_MIN_AMP     = 8'd45;
  localparam logic [7:0]  RST_START_THR   = 8'd144;
  localparam logic [7:0]  RST_BIT_THR     = 8'd112;

  // What one cell hands to the next cell every cycle.
  typedef struct packed {
    logic            en;
    logic [PH_W-1:0] phase;
  } ccl21_link_t;

  // Run-in sums a cell has gathered for its candidate offset.
  typedef struct packed {
    logic [SUM_W-1:0] hi_sum;
    logic [CNT_W-1:0] hi_cnt;
    logic [SUM_W-1:0] lo_sum;
    logic [CNT_W-1:0] lo_cnt;
  } ccl21_acc_t;

endpackage

### rtl/ccl21_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; used for the line store.
`timescale 1ns / 1ps
module ccl21_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/ccl21_cell.sv
// One run-in candidate cell: accumulates high and low phase sample sums.
// Depends on ccl21_pkg; a row of these forms the run-in search chain.
`timescale 1ns / 1ps
module ccl21_cell
  import ccl21_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clr_i,
  input  ccl21_link_t link_i,
  input  logic [7:0]  sample_i,
  output ccl21_link_t link_o,
  output ccl21_acc_t  acc_o
);

  logic       en_q;
  logic [PH_W-1:0] phase_q;
  ccl21_acc_t acc_q;
  logic       low_ph;

  assign low_ph = (link_i.phase < PHASE_LOW_EDGE) || (link_i.phase > PHASE_HIGH_EDGE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= link_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= link_i.phase;
    if (clr_i) begin
      acc_q <= '0;
    end else if (link_i.en) begin
      if (low_ph) begin
        acc_q.lo_sum <= acc_q.lo_sum + SUM_W'(sample_i);
        acc_q.lo_cnt <= acc_q.lo_cnt + CNT_W'(1);
      end else begin
        acc_q.hi_sum <= acc_q.hi_sum + SUM_W'(sample_i);
        acc_q.hi_cnt <= acc_q.hi_cnt + CNT_W'(1);
      end
    end
  end

  assign link_o.en    = en_q;
  assign link_o.phase = phase_q;
  assign acc_o        = acc_q;

endmodule

### rtl/ccl21_div.sv
// Restoring divider giving the 8-bit mean of a sample sum, one bit a cycle.
// Depends on ccl21_pkg; the quotient is known to stay below 256.
`timescale 1ns / 1ps
module ccl21_div
  import ccl21_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [CNT_W-1:0] cnt_i,
  output logic [7:0]       quot_o,
  output logic             done_o
);

  logic             busy_q, done_q;
  logic [2:0]       step_q;
  logic [SUM_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic [7:0]       quot_q;
  logic [SUM_W-1:0] trial;
  logic             ge;

  assign trial = SUM_W'(cnt_q) << step_q;
  assign ge    = rem_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd7;
      end else if (busy_q) begin
        step_q <= step_q - 3'd1;
        if (step_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= sum_i;
      cnt_q <= cnt_i;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_q - trial : rem_q;
      quot_q <= {quot_q[6:0], ge};
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

### rtl/cc_line21_slicer.sv
// Top level of the line 21 caption data slicer.
// Depends on ccl21_pkg, ccl21_ram, ccl21_cell and ccl21_div.
//
// Usage: samples of one VBI line arrive on the s_axis channel, one request
// per cycle, tdata carrying the 8-bit sample and tlast marking the last
// sample of the line. Samples go into a 2048-entry line store. The request
// with tlast starts the decode and s_axis_tready stays low until the decode
// has finished. Exactly one result per line leaves on m_axis: tdata holds the
// 16-bit code and tuser the found flag.
// Decode sweeps the run-in window through the row of 15 candidate cells,
// forms the two means of each candidate in the shared serial dividers, and
// then slices each bit window out of the single read port of the line
// store (up to 17 windows).
// The configuration channel takes a write every cycle; write it only while
// the block is idle. Reset returns the registers to their defaults and the
// write position to zero; the line store is not cleared.
// If the receiver stalls m_axis, the result holds and the block keeps
// taking samples of the next line and decodes it, but it holds the new
// result back in its last decode step until the waiting one is taken.
`timescale 1ns / 1ps
module cc_line21_slicer
  import ccl21_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code
  output logic [0:0]  m_axis_tuser,   // [0] found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STREAM = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DWAIT  = 3'd3;
  localparam logic [2:0] ST_SLICE  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  localparam int RD_W = ADDR_W;  // wide enough for window_len + N_CELLS reads

  logic [2:0]  state_q, state_d;
  logic [15:0] recip_q;
  logic [WL_W-1:0] wlen_q;
  logic [7:0]  min_amp_q, start_thr_q, bit_thr_q;

  logic [ADDR_W-1:0] wpos_q;
  logic              in_acc;

  logic [RD_W-1:0]   issue_q;
  logic [RD_W-1:0]   gen_i_q;
  logic [PH_W-1:0]   gen_ph_q;
  logic              dv_q;
  logic              issue;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic              clr;

  ccl21_link_t link [N_CELLS+1];
  ccl21_acc_t  acc  [N_CELLS];

  logic [CELL_W-1:0] ci_q;
  logic signed [9:0] best_q, score;
  logic [7:0]        q_hi, q_lo;
  logic              done_hi, done_lo, div_start;
  ccl21_acc_t        sel;

  logic [4:0]        bk_q;
  logic [WIN_W-1:0]  j_q;
  logic [ADDR_W-1:0] base_q;
  logic [BSUM_W-1:0] bsum_q;
  logic [BSUM_W-1:0] bthr;
  logic              bit_one;
  logic [15:0]       bits_q;
  logic              found_q;

  logic              out_valid_q;
  logic [15:0]       out_code_q;
  logic              out_found_q;
  logic              out_free;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_q     <= RST_CLOCK_RECIP;
      wlen_q      <= RST_WINDOW_LEN;
      min_amp_q   <= RST_MIN_AMP;
      start_thr_q <= RST_START_THR;
      bit_thr_q   <= RST_BIT_THR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CLOCK_RECIP: recip_q     <= cfg_data_i;
        REG_WINDOW_LEN:  wlen_q      <= cfg_data_i[WL_W-1:0];
        REG_MIN_AMP:     min_amp_q   <= cfg_data_i[7:0];
        REG_START_THR:   start_thr_q <= cfg_data_i[7:0];
        REG_BIT_THR:     bit_thr_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Line store.
  assign issue = ((state_q == ST_STREAM) &&
                  (issue_q < RD_W'(wlen_q) + RD_W'(N_CELLS - 1))) ||
                 ((state_q == ST_SLICE) && (j_q < WIN_W'(BIT_WINDOW)));
  assign raddr = (state_q == ST_STREAM) ? ADDR_W'(SEARCH_FIRST) + issue_q[ADDR_W-1:0]
                                        : base_q + ADDR_W'(j_q);

  ccl21_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(wpos_q),
    .wdata_i(s_axis_tdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Phase generator feeding the head of the cell row. Each cell sees the
  // window index delayed by its place in the row, which matches its offset.
  assign link[0].en    = dv_q && (state_q == ST_STREAM) && (gen_i_q < RD_W'(wlen_q));
  assign link[0].phase = gen_ph_q;
  assign clr           = in_acc && s_axis_tlast;

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    ccl21_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (clr),
      .link_i  (link[k]),
      .sample_i(rdata),
      .link_o  (link[k+1]),
      .acc_o   (acc[k])
    );
  end

  // Mean and score of one candidate at a time.
  assign sel       = acc[ci_q];
  assign div_start = (state_q == ST_DSTART);

  ccl21_div u_div_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (sel.hi_sum),
    .cnt_i  (sel.hi_cnt),
    .quot_o (q_hi),
    .done_o (done_hi)
  );

  ccl21_div u_div_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (sel.lo_sum),
    .cnt_i  (sel.lo_cnt),
    .quot_o (q_lo),
    .done_o (done_lo)
  );

  assign score = ((sel.hi_cnt == '0) || (sel.lo_cnt == '0)) ? 10'sd0
               : $signed({2'b00, q_hi}) - $signed({2'b00, q_lo});

  assign bthr    = BSUM_W'((bk_q == 5'd0) ? start_thr_q : bit_thr_q) * BSUM_W'(BIT_WINDOW);
  assign bit_one = bsum_q > bthr;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (clr) state_d = ST_STREAM;
      ST_STREAM: if (!issue && !dv_q) state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (done_hi && done_lo) begin
          if (ci_q != CELL_W'(N_CELLS - 1)) begin
            state_d = ST_DSTART;
          end else if (((score > best_q) ? score : best_q) <
                       $signed({2'b00, min_amp_q})) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SLICE;
          end
        end
      end
      ST_SLICE: begin
        if (!issue && !dv_q && j_q == WIN_W'(BIT_WINDOW)) begin
          if ((bk_q == 5'd0 && !bit_one) || bk_q == 5'd16) state_d = ST_FINISH;
        end
      end
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wpos_q      <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= issue;
      if (in_acc) begin
        wpos_q <= s_axis_tlast ? '0 : wpos_q + ADDR_W'(1);
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        issue_q  <= '0;
        gen_i_q  <= '0;
        gen_ph_q <= '0;
        ci_q     <= '0;
        best_q   <= -10'sd1;
        found_q  <= 1'b0;
        bits_q   <= '0;
      end
      ST_STREAM: begin
        if (issue) issue_q <= issue_q + RD_W'(1);
        if (dv_q) begin
          gen_i_q  <= gen_i_q + RD_W'(1);
          gen_ph_q <= gen_ph_q + recip_q;
        end
      end
      ST_DWAIT: begin
        if (done_hi && done_lo) begin
          if (score > best_q) begin
            best_q     <= score;
            base_q     <= ADDR_W'(SEARCH_FIRST + START_OFFSET) + ADDR_W'(ci_q);
          end
          ci_q   <= ci_q + CELL_W'(1);
          bk_q   <= '0;
          j_q    <= '0;
          bsum_q <= '0;
        end
      end
      ST_SLICE: begin
        if (issue) j_q <= j_q + WIN_W'(1);
        if (dv_q) bsum_q <= bsum_q + BSUM_W'(rdata);
        if (!issue && !dv_q && j_q == WIN_W'(BIT_WINDOW)) begin
          if (bk_q != 5'd0) bits_q <= {bit_one, bits_q[15:1]};
          if (bk_q == 5'd16) found_q <= 1'b1;
          bk_q   <= bk_q + 5'd1;
          j_q    <= '0;
          bsum_q <= '0;
          base_q <= base_q + ADDR_W'(BIT_SPACING);
        end
      end
      default: ;
    endcase
    if (state_q == ST_FINISH && out_free) begin
      out_found_q <= found_q;
      // A byte whose odd parity fails is zeroed.
      out_code_q  <= found_q ? {bits_q[15:8] & {8{^bits_q[15:8]}},
                                bits_q[7:0] & {8{^bits_q[7:0]}}} : 16'd0;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_code_q;
  assign m_axis_tuser[0] = out_found_q;

endmodule

### rtl/ccl21_chk.sv
// Port-level checker for the line 21 caption data slicer, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module ccl21_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // A line that was not found carries no code.
  a_nofound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
    else $error("code not zero without found");

  // The end of a line starts a decode, which stops sample intake.
  a_decode_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("samples taken right after line end");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

endmodule

bind cc_line21_slicer ccl21_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

### tb/tb.sv
// Self-checking testbench for the line 21 caption data slicer.
// Drives whole VBI lines and register writes, predicts each decoded code, and
// compares the results. Depends on ccl21_pkg and cc_line21_slicer.
`timescale 1ns / 1ps

class caption_board;
  bit [7:0]   line_mem[ccl21_pkg::LINE_DEPTH];
  int         wpos;
  bit [15:0]  recip;
  bit [9:0]   wlen;
  bit [7:0]   min_amp, start_thr, bit_thr;
  bit [16:0]  pending[$];   // {found, code}
  int         errors;

  function new();
    wpos      = 0;
    recip     = ccl21_pkg::RST_CLOCK_RECIP;
    wlen      = ccl21_pkg::RST_WINDOW_LEN;
    min_amp   = ccl21_pkg::RST_MIN_AMP;
    start_thr = ccl21_pkg::RST_START_THR;
    bit_thr   = ccl21_pkg::RST_BIT_THR;
    errors    = 0;
  endfunction

  function void set_reg(bit [2:0] idx, bit [15:0] v);
    case (idx)
      ccl21_pkg::REG_CLOCK_RECIP: recip = v;
      ccl21_pkg::REG_WINDOW_LEN:  wlen = v[9:0];
      ccl21_pkg::REG_MIN_AMP:     min_amp = v[7:0];
      ccl21_pkg::REG_START_THR:   start_thr = v[7:0];
      ccl21_pkg::REG_BIT_THR:     bit_thr = v[7:0];
      default: ;
    endcase
  endfunction

  function int runin_score(int base);
    int hs, hc, ls, lc;
    bit [15:0] ph;
    hs = 0; hc = 0; ls = 0; lc = 0;
    for (int i = 0; i < wlen; i++) begin
      ph = 16'(i * recip);
      if (ph < ccl21_pkg::PHASE_LOW_EDGE || ph > ccl21_pkg::PHASE_HIGH_EDGE) begin
        ls += line_mem[(base + i) % ccl21_pkg::LINE_DEPTH];
        lc++;
      end else begin
        hs += line_mem[(base + i) % ccl21_pkg::LINE_DEPTH];
        hc++;
      end
    end
    if (hc == 0 || lc == 0) return 0;
    return hs / hc - ls / lc;
  endfunction

  function bit window_high(int p, int thr);
    int sum;
    sum = 0;
    for (int i = 0; i < ccl21_pkg::BIT_WINDOW; i++)
      sum += line_mem[(p + i) % ccl21_pkg::LINE_DEPTH];
    return sum > thr * ccl21_pkg::BIT_WINDOW;
  endfunction

  function bit [16:0] decode_line();
    int best, best_pos, sc, p;
    bit [15:0] bits;
    best = -1;
    best_pos = 0;
    bits = '0;
    for (int c = ccl21_pkg::SEARCH_FIRST; c < ccl21_pkg::SEARCH_END; c++) begin
      sc = runin_score(c);
      if (sc > best) begin
        best = sc;
        best_pos = c;
      end
    end
    if (best < int'(min_amp)) return '0;
    p = best_pos + ccl21_pkg::START_OFFSET;
    if (!window_high(p, start_thr)) return '0;
    p += ccl21_pkg::BIT_SPACING;
    for (int i = 0; i < 16; i++)
      bits[i] = window_high(p + i * ccl21_pkg::BIT_SPACING, bit_thr);
    // A byte with even parity is dropped to zero.
    if (!(^bits[7:0])) bits[7:0] = '0;
    if (!(^bits[15:8])) bits[15:8] = '0;
    return {1'b1, bits};
  endfunction

  function void note_sample(bit [7:0] s, bit last);
    line_mem[wpos] = s;
    wpos = (wpos + 1) % ccl21_pkg::LINE_DEPTH;
    if (last) begin
      pending.push_back(decode_line());
      wpos = 0;
    end
  endfunction

  function void check_code(bit [15:0] code, bit found);
    bit [16:0] want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: code %h found %b", code, found);
      return;
    end
    want = pending.pop_front();
    if (want != {found, code}) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected code %h found %b, got code %h found %b",
                 want[15:0], want[16], code, found);
    end
  endfunction
endclass

module tb;
  import ccl21_pkg::*;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  caption_board board;
  bit           calm;
  int           quiet_cycles;
  bit [7:0]     pix[];

  localparam int QUIET_LIMIT = 20000;

  cc_line21_slicer DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Results are checked, and a stall of the block is caught by the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_code(m_axis_tdata, m_axis_tuser[0]);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        m_axis_tready = 1'b1;
      end else if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if ($urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        stall = $urandom_range(0, 4);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic push_sample(bit [7:0] s, bit last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = s;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(s, last);
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (pix[i]) push_sample(pix[i], i == pix.size() - 1);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
  endtask

  task automatic write_reg(bit [2:0] idx, bit [15:0] v);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Writes only happen once every line has been answered.
  task automatic set_regs(bit [15:0] r, bit [9:0] w, bit [7:0] a, bit [7:0] st,
                          bit [7:0] bt);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    @(negedge clk_i);
    write_reg(REG_CLOCK_RECIP, r);
    write_reg(REG_WINDOW_LEN, {6'd0, w});
    write_reg(REG_MIN_AMP, {8'd0, a});
    write_reg(REG_START_THR, {8'd0, st});
    write_reg(REG_BIT_THR, {8'd0, bt});
  endtask

  function automatic bit [7:0] odd_byte();
    bit [7:0] b;
    b = 8'($urandom);
    b[7] = ~^b[6:0];
    return b;
  endfunction

  function automatic bit [7:0] noisy(int lvl);
    int v;
    v = lvl + $urandom_range(0, 16) - 8;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // Builds a line with a run-in at offset ro, a start bit and a 16-bit word.
  function automatic void make_caption(int len, int ro, int lo, int hi, bit start_one,
                                       bit [15:0] word);
    bit [15:0] ph;
    int slot;
    pix = new[len];
    foreach (pix[p]) pix[p] = noisy(lo);
    for (int p = ro; p < ro + int'(board.wlen) + 20 && p < len; p++) begin
      ph = 16'((p - ro) * board.recip);
      pix[p] = noisy((ph < PHASE_LOW_EDGE || ph > PHASE_HIGH_EDGE) ? lo : hi);
    end
    for (int k = 0; k < 17; k++) begin
      slot = ro + START_OFFSET + BIT_SPACING * k - 10;
      if ((k == 0) ? start_one : word[k-1])
        for (int p = slot; p < slot + BIT_SPACING && p < len; p++) pix[p] = noisy(hi);
    end
  endfunction

  function automatic void make_flat(int len, int lvl, bit rough);
    pix = new[len];
    foreach (pix[p]) pix[p] = rough ? 8'($urandom) : 8'(lvl);
  endfunction

  // Short lines; the longer ones reach into the first run-in candidates and
  // the rest of the store keeps what earlier lines left there.
  task automatic random_line();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 9)
      make_flat($urandom_range(1, 6), $urandom_range(0, 255), $urandom_range(0, 1) != 0);
    else
      make_flat($urandom_range(36, 48), $urandom_range(0, 255), $urandom_range(0, 1) != 0);
    send_line();
  endtask

  initial begin
    board = new();
    calm = 1'b0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed lines; the first one fills every position the decode reads.
    make_caption(1500, 40, 20, 220, 1'b1, {odd_byte(), odd_byte()});
    send_line();
    make_flat(1, 0, 1'b1);
    send_line();
    make_flat(40, 255, 1'b0);
    send_line();

    set_regs(16'd1, 10'd1, 8'd0, 8'd0, 8'd0);
    repeat (4) random_line();
    set_regs(16'hFFFF, 10'd1023, 8'd255, 8'd255, 8'd255);
    repeat (4) random_line();
    set_regs(16'd1152, 10'd1023, 8'd0, 8'd255, 8'd0);
    repeat (4) random_line();
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(16'($urandom_range(900, 1500)), 10'($urandom_range(1, 1023)),
               8'($urandom_range(0, 90)), 8'($urandom_range(100, 200)),
               8'($urandom_range(60, 160)));
      repeat (6) random_line();
    end
    set_regs(RST_CLOCK_RECIP, RST_WINDOW_LEN, RST_MIN_AMP, RST_START_THR, RST_BIT_THR);
    calm = 1'b1;
    repeat (6) random_line();

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

### sim.f
rtl/ccl21_pkg.sv
rtl/ccl21_ram.sv
rtl/ccl21_cell.sv
rtl/ccl21_div.sv
rtl/cc_line21_slicer.sv
rtl/ccl21_chk.sv
tb/tb.sv
